>>> rtl/core/bmbp_pkg.sv
// shared constants and types for the block minimum bit packer
package bmbp_pkg;
   localparam int MAX_BLOCK   = 64;
   localparam int HEIGHT_BITS = 16;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(MAX_BLOCK);
   localparam int CNT_BITS    = $clog2(MAX_BLOCK + 1);

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_RAW    = 2'd2;

   localparam logic [1:0] CSR_BLOCK_LEN = 2'd0;
   localparam logic [1:0] CSR_STEP      = 2'd1;
   localparam logic [1:0] CSR_RAW_MODE  = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] base;
      logic [4:0]  width;
      logic [31:0] bit_pointer;
      logic [31:0] word;
      logic        last;
   } rsp_type;
endpackage

>>> rtl/core/bmbp_store.sv
// sample store: one write port, one registered read port
module bmbp_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [bmbp_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [15:0]                    wr_data,
   input  logic [bmbp_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [15:0]                    rd_data
);
   import bmbp_pkg::*;
   logic [15:0] mem [MAX_BLOCK];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/bmbp_divider.sv
// restoring divider, one quotient bit per cycle
module bmbp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   import bmbp_pkg::*;
   logic [16:0] rem_ff;
   logic [15:0] quo_ff, den_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff;
   logic [16:0] trial;
   always_comb trial = {rem_ff[15:0], quo_ff[15]} - {1'b0, den_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 5'd16;
            rem_ff <= '0;
            quo_ff <= dividend;
            den_ff <= divisor;
         end else if (run_ff) begin
            if (!trial[16]) begin
               rem_ff <= trial;
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[15:0], quo_ff[15]};
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
            end
         end
      end
   end
   assign quotient = quo_ff;
endmodule

>>> rtl/core/block_min_bitpack_compressor_unit.sv
// top level of the block minimum bit packer
// a raw transaction answers in the cycle after start; a sample that does not end a
// block is stored and the minimum updated; a block end stores its sample, reads every
// stored sample for the largest difference, searches the width, emits the header and,
// for a nonzero width, reads, divides and packs each sample; end of field adds a flush
// busy is high in every state but idle; start is taken only while busy is low
// reset: synchronous active high, state and settings to reset values; store not cleared
// the receiver cannot stall: each result is held one cycle under rsp_valid
module block_min_bitpack_compressor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_height,
   input  logic        req_end_of_field,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_base,
   output logic [4:0]  rsp_width,
   output logic [31:0] rsp_bit_pointer,
   output logic [31:0] rsp_word,
   output logic        rsp_last
);
   import bmbp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_MAXRD, S_MAXACC, S_WIDTH, S_HDR,
      S_RD, S_DIVGO, S_DIVW, S_PACK, S_PACK2, S_FLUSH
   } state_type;

   state_type state_ff;
   logic [6:0]  len_ff;
   logic [15:0] step_ff;
   logic        raw_ff;
   logic [15:0] min_ff;
   logic [CNT_BITS-1:0] fill_ff, idx_ff, n_ff;
   logic [31:0] pw_ff;
   logic [4:0]  pb_ff;
   logic [31:0] bc_ff;
   logic [15:0] maxd_ff;
   logic [4:0]  w_ff;
   logic        eof_ff;
   logic [15:0] h_ff;
   logic [15:0] rd_data;
   logic [15:0] q_ff;
   logic [5:0]  wl_ff;   // data words still to come in this block
   logic        fl_ff;   // a flush word follows the block
   rsp_type     rsp_ff;

   logic        div_start, div_done;
   logic [15:0] div_q;
   logic [ADDR_BITS-1:0] rd_addr;
   logic        st_we;

   // clamp block length to 1..MAX_BLOCK
   logic [CNT_BITS-1:0] len_c;
   always_comb begin
      if (len_ff == 7'd0) len_c = CNT_BITS'(1);
      else if (32'(len_ff) > MAX_BLOCK) len_c = CNT_BITS'(MAX_BLOCK);
      else len_c = CNT_BITS'(len_ff);
   end

   assign busy  = (state_ff != S_IDLE);
   assign st_we = (state_ff == S_LOAD) && (fill_ff < CNT_BITS'(MAX_BLOCK));
   assign rd_addr = idx_ff[ADDR_BITS-1:0];

   bmbp_store u_store (
      .clock, .wr_en(st_we), .wr_addr(fill_ff[ADDR_BITS-1:0]),
      .wr_data(h_ff), .rd_addr, .rd_data
   );

   logic [15:0] diff;
   assign diff = rd_data - min_ff;
   assign div_start = (state_ff == S_DIVGO);
   bmbp_divider u_div (
      .clock, .reset, .start(div_start), .dividend(diff), .divisor(step_ff),
      .done(div_done), .quotient(div_q)
   );

   // width search: one candidate per cycle, compare (2^w-1)*step against max difference
   logic [32:0] lim;
   assign lim = 33'(((32'd1 << w_ff) - 32'd1)) * 33'(step_ff);

   // pending bits once the block is packed: upper bits count full words
   logic [10:0] tot;
   assign tot = 11'(pb_ff) + 11'(w_ff) * 11'(n_ff);

   // packer: append w bits of q_ff
   logic [5:0]  room;
   logic [63:0] cat;
   assign room = 6'd32 - 6'(pb_ff);
   assign cat  = ({32'd0, pw_ff} << w_ff) | 64'(q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= 7'd16; step_ff <= 16'd1; raw_ff <= 1'b0;
         min_ff <= '1; fill_ff <= '0; pw_ff <= '0; pb_ff <= '0; bc_ff <= '0;
         rsp_ff <= '0;
      end else begin
         rsp_ff.valid <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_LEN: len_ff  <= csr_wdata[6:0];
               CSR_STEP:      step_ff <= csr_wdata;
               CSR_RAW_MODE:  raw_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (start) begin
               h_ff <= req_height; eof_ff <= req_end_of_field;
               if (raw_ff) begin
                  rsp_ff <= '{1'b1, KIND_RAW, req_height, 5'd0, 32'd0, 32'd0,
                     !(req_end_of_field && pb_ff != 5'd0)};
                  state_ff <= req_end_of_field ? S_FLUSH : S_IDLE;
               end else state_ff <= S_LOAD;
            end
            S_LOAD: begin
               fill_ff <= fill_ff + CNT_BITS'(1);
               if (h_ff < min_ff) min_ff <= h_ff;
               if (fill_ff + CNT_BITS'(1) >= len_c) begin
                  n_ff <= fill_ff + CNT_BITS'(1);
                  idx_ff <= '0; maxd_ff <= '0;
                  state_ff <= S_MAXRD;
               end else state_ff <= eof_ff ? S_FLUSH : S_IDLE;
            end
            S_MAXRD: state_ff <= S_MAXACC;
            S_MAXACC: begin
               if (diff > maxd_ff) maxd_ff <= diff;
               if (idx_ff + CNT_BITS'(1) == n_ff) begin
                  w_ff <= '0; state_ff <= S_WIDTH;
               end else begin
                  idx_ff <= idx_ff + CNT_BITS'(1); state_ff <= S_MAXRD;
               end
            end
            S_WIDTH: begin
               if (step_ff != 16'd0 && w_ff < 5'd16 && lim < 33'(maxd_ff))
                  w_ff <= w_ff + 5'd1;
               else if (step_ff == 16'd0) begin
                  w_ff <= '0; state_ff <= S_HDR;
               end else state_ff <= S_HDR;
            end
            S_HDR: begin
               // header is last when no word fills and no flush follows
               rsp_ff <= '{1'b1, KIND_HEADER, min_ff, w_ff, bc_ff, 32'd0,
                  (tot[10:5] == 6'd0) && !(eof_ff && tot[4:0] != 5'd0)};
               wl_ff <= tot[10:5];
               fl_ff <= eof_ff && (tot[4:0] != 5'd0);
               idx_ff <= '0;
               if (w_ff == 5'd0) begin
                  min_ff <= '1; fill_ff <= '0;
                  state_ff <= eof_ff ? S_FLUSH : S_IDLE;
               end else begin
                  bc_ff <= bc_ff + 32'(w_ff) * 32'(n_ff);
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_DIVGO;
            S_DIVGO: state_ff <= S_DIVW;
            S_DIVW: if (div_done) begin
               q_ff <= div_q; state_ff <= S_PACK;
            end
            S_PACK: begin
               if (6'(w_ff) < room) begin
                  pw_ff <= cat[31:0]; pb_ff <= pb_ff + w_ff;
                  state_ff <= S_PACK2;
               end else begin
                  rsp_ff <= '{1'b1, KIND_DATA, 16'd0, 5'd0, 32'd0,
                     32'(cat >> (6'(w_ff) - room)),
                     (wl_ff == 6'd1) && !fl_ff};
                  wl_ff <= wl_ff - 6'd1;
                  pw_ff <= 32'(q_ff & 16'((17'd1 << (6'(w_ff) - room)) - 17'd1));
                  pb_ff <= 5'(6'(w_ff) - room);
                  state_ff <= S_PACK2;
               end
            end
            S_PACK2: begin
               if (idx_ff + CNT_BITS'(1) == n_ff) begin
                  min_ff <= '1; fill_ff <= '0;
                  state_ff <= eof_ff ? S_FLUSH : S_IDLE;
               end else begin
                  idx_ff <= idx_ff + CNT_BITS'(1); state_ff <= S_RD;
               end
            end
            S_FLUSH: begin
               if (pb_ff != 5'd0)
                  rsp_ff <= '{1'b1, KIND_DATA, 16'd0, 5'd0, 32'd0,
                     pw_ff << (6'd32 - 6'(pb_ff)), 1'b1};
               min_ff <= '1; fill_ff <= '0; pw_ff <= '0; pb_ff <= '0; bc_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_ff.valid;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_base        = rsp_ff.base;
   assign rsp_width       = rsp_ff.width;
   assign rsp_bit_pointer = rsp_ff.bit_pointer;
   assign rsp_word        = rsp_ff.word;
   assign rsp_last        = rsp_ff.last;

   // flush always empties the partial word
   a_pb: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |=> pb_ff == 5'd0) else $error("flush left bits");
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |-> rsp_width <= 5'd16)
      else $error("width out of range");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(MAX_BLOCK)) else $error("fill overrun");
endmodule
